// ----- hw/rtl/sfs_pkg.sv -----
`timescale 1ns / 1ps

package sfs_pkg;

	// Default sizes handed to the top level parameters.
	localparam int unsigned MAX_FRAMES_DEF = 16;
	localparam int unsigned TIME_BITS_DEF  = 24;
	localparam int unsigned COORD_BITS_DEF = 12;

	// Register port geometry.
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	// Register values after reset.
	localparam int unsigned RST_FRAME_WIDTH  = 16;
	localparam int unsigned RST_FRAME_HEIGHT = 16;
	localparam int unsigned RST_ORIGIN_X     = 0;
	localparam int unsigned RST_ORIGIN_Y     = 0;
	localparam int unsigned RST_SHEET_WIDTH  = 256;
	localparam int unsigned RST_FRAME_COUNT  = 1;

	// Register indexes, taken from paddr[4:2].
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_SHEET_WIDTH,
		REG_FRAME_COUNT
	} reg_idx_t;

	// Request action codes.
	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_LOAD    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Which division the shared divider performs.
	typedef enum logic [1:0] {
		DIV_ROW,
		DIV_X,
		DIV_Y
	} div_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    take_tick;
		logic    load_dur;
		logic    restart;
		logic    fetch;
		logic    step;
		logic    decide;
		logic    div_start;
		div_op_t div_op;
		logic    row_latch;
		logic    x_latch;
		logic    y_latch;
		logic    emit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic out_free;
	} ctl_sts_t;

endpackage

// ----- hw/rtl/sfs_cmd_if.sv -----
`timescale 1ns / 1ps

// Request channel: ticks, duration loads and restarts.
interface sfs_cmd_if #(
	parameter int unsigned TIME_BITS  = 24,
	parameter int unsigned INDEX_BITS = 4
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [TIME_BITS-1:0]  delta;
	logic [INDEX_BITS-1:0] entry_index;
	logic [TIME_BITS-1:0]  duration;

	modport source (output valid, action, delta, entry_index, duration, input ready);
	modport sink   (input valid, action, delta, entry_index, duration, output ready);
endinterface

// ----- hw/rtl/sfs_rect_if.sv -----
`timescale 1ns / 1ps

// Result channel: one source rectangle per tick.
interface sfs_rect_if #(
	parameter int unsigned COORD_BITS = 12,
	parameter int unsigned INDEX_BITS = 4
);
	logic                    valid;
	logic                    ready;
	logic [COORD_BITS-1:0]   src_x;
	logic [COORD_BITS+3:0]   src_y;
	logic [COORD_BITS-1:0]   src_w;
	logic [COORD_BITS-1:0]   src_h;
	logic [INDEX_BITS-1:0]   shown_frame;

	modport source (output valid, src_x, src_y, src_w, src_h, shown_frame, input ready);
	modport sink   (input valid, src_x, src_y, src_w, src_h, shown_frame, output ready);
endinterface

// ----- hw/rtl/sfs_ram.sv -----
`timescale 1ns / 1ps

// Generic single write port, single read port RAM with registered read data.
module sfs_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/sfs_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned with its significant bits at the top, and nbits says how
// many of them to work through.
module sfs_div #(
	parameter int unsigned DW = 16,
	parameter int unsigned VW = 12,
	localparam int unsigned NBW = $clog2(DW + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dividend,
	input  logic [NBW-1:0] nbits,
	input  logic [VW-1:0]  divisor,
	output logic           done,
	output logic [DW-1:0]  quotient,
	output logic [VW-1:0]  remainder
);

	logic [DW-1:0]  dvd_q;
	logic [VW-1:0]  rem_q;
	logic [VW-1:0]  dsr_q;
	logic [NBW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [VW:0]    rem_sh;
	logic           take;
	logic [VW:0]    rem_sub;

	// One trial subtraction of the divisor from the shifted partial remainder.
	assign rem_sh  = {rem_q, dvd_q[DW-1]};
	assign take    = (rem_sh >= {1'b0, dsr_q});
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	// Payload shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], take};
			rem_q <= take ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	// Iteration count and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= nbits;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - NBW'(1);
			if (cnt_q == NBW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// ----- hw/rtl/sfs_regs.sv -----
`timescale 1ns / 1ps

// Configuration register file behind the APB-style port.
module sfs_regs #(
	parameter int unsigned COORD_BITS = 12,
	parameter int unsigned CNT_BITS   = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sfs_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sfs_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	output logic [COORD_BITS-1:0]         frame_width,
	output logic [COORD_BITS-1:0]         frame_height,
	output logic [COORD_BITS-1:0]         origin_x,
	output logic [COORD_BITS-1:0]         origin_y,
	output logic [COORD_BITS-1:0]         sheet_width,
	output logic [CNT_BITS-1:0]           frame_count
);

	logic              wr_en;
	sfs_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = sfs_pkg::reg_idx_t'(paddr[4:2]);

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width  <= COORD_BITS'(sfs_pkg::RST_FRAME_WIDTH);
			frame_height <= COORD_BITS'(sfs_pkg::RST_FRAME_HEIGHT);
			origin_x     <= COORD_BITS'(sfs_pkg::RST_ORIGIN_X);
			origin_y     <= COORD_BITS'(sfs_pkg::RST_ORIGIN_Y);
			sheet_width  <= COORD_BITS'(sfs_pkg::RST_SHEET_WIDTH);
			frame_count  <= CNT_BITS'(sfs_pkg::RST_FRAME_COUNT);
		end else if (wr_en) begin
			case (idx)
				sfs_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[COORD_BITS-1:0];
				sfs_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[COORD_BITS-1:0];
				sfs_pkg::REG_ORIGIN_X:     origin_x     <= pwdata[COORD_BITS-1:0];
				sfs_pkg::REG_ORIGIN_Y:     origin_y     <= pwdata[COORD_BITS-1:0];
				sfs_pkg::REG_SHEET_WIDTH:  sheet_width  <= pwdata[COORD_BITS-1:0];
				sfs_pkg::REG_FRAME_COUNT:  frame_count  <= pwdata[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero-extended.
	always_comb begin
		case (idx)
			sfs_pkg::REG_FRAME_WIDTH:  prdata = sfs_pkg::APB_DATA_W'(frame_width);
			sfs_pkg::REG_FRAME_HEIGHT: prdata = sfs_pkg::APB_DATA_W'(frame_height);
			sfs_pkg::REG_ORIGIN_X:     prdata = sfs_pkg::APB_DATA_W'(origin_x);
			sfs_pkg::REG_ORIGIN_Y:     prdata = sfs_pkg::APB_DATA_W'(origin_y);
			sfs_pkg::REG_SHEET_WIDTH:  prdata = sfs_pkg::APB_DATA_W'(sheet_width);
			sfs_pkg::REG_FRAME_COUNT:  prdata = sfs_pkg::APB_DATA_W'(frame_count);
			default:                   prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/sfs_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer for one tick: timing update, then the three divisions, then the
// hand-over to the output register. Loads and restarts are issued from idle.
module sfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [1:0]        cmd_action,
	output logic              cmd_ready,
	input  sfs_pkg::ctl_sts_t sts,
	output sfs_pkg::ctl_cmd_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_STEP,
		S_DECIDE,
		S_ROW,
		S_XDIV,
		S_YDIV,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (cmd_action == sfs_pkg::ACT_TICK)) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH:  state_q <= S_STEP;
				S_STEP:   state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_ROW;
				S_ROW: begin
					if (sts.div_done) begin
						state_q <= S_XDIV;
					end
				end
				S_XDIV: begin
					if (sts.div_done) begin
						state_q <= S_YDIV;
					end
				end
				S_YDIV: begin
					if (sts.div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		ctl        = '0;
		ctl.div_op = sfs_pkg::DIV_ROW;
		case (state_q)
			S_IDLE: begin
				ctl.take_tick = accept && (cmd_action == sfs_pkg::ACT_TICK);
				ctl.load_dur  = accept && (cmd_action == sfs_pkg::ACT_LOAD);
				ctl.restart   = accept && (cmd_action == sfs_pkg::ACT_RESTART);
			end
			S_FETCH: ctl.fetch = 1'b1;
			S_STEP:  ctl.step  = 1'b1;
			S_DECIDE: begin
				ctl.decide    = 1'b1;
				ctl.div_start = 1'b1;
				ctl.div_op    = sfs_pkg::DIV_ROW;
			end
			S_ROW: begin
				ctl.row_latch = sts.div_done;
				ctl.div_start = sts.div_done;
				ctl.div_op    = sfs_pkg::DIV_X;
			end
			S_XDIV: begin
				ctl.x_latch   = sts.div_done;
				ctl.div_start = sts.div_done;
				ctl.div_op    = sfs_pkg::DIV_Y;
			end
			S_YDIV:  ctl.y_latch = sts.div_done;
			S_EMIT:  ctl.emit    = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/sfs_dp.sv -----
`timescale 1ns / 1ps

// Datapath: animation state, duration store, timing arithmetic, the shared
// divider and the output register.
module sfs_dp #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned TIME_BITS  = 24,
	parameter int unsigned COORD_BITS = 12,
	localparam int unsigned FW   = $clog2(MAX_FRAMES),
	localparam int unsigned CNTW = $clog2(MAX_FRAMES + 1),
	localparam int unsigned CB   = COORD_BITS,
	localparam int unsigned YW   = COORD_BITS + 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfs_pkg::ctl_cmd_t    ctl,
	output sfs_pkg::ctl_sts_t    sts,
	input  logic [TIME_BITS-1:0] delta,
	input  logic [FW-1:0]        entry_index,
	input  logic [TIME_BITS-1:0] duration,
	input  logic [CB-1:0]        frame_width,
	input  logic [CB-1:0]        frame_height,
	input  logic [CB-1:0]        origin_x,
	input  logic [CB-1:0]        origin_y,
	input  logic [CB-1:0]        sheet_width,
	input  logic [CNTW-1:0]      frame_count,
	input  logic                 rect_ready,
	output logic                 rect_valid,
	output logic [CB-1:0]        src_x,
	output logic [YW-1:0]        src_y,
	output logic [CB-1:0]        src_w,
	output logic [CB-1:0]        src_h,
	output logic [FW-1:0]        shown_frame
);

	localparam int unsigned TB  = TIME_BITS;
	localparam int unsigned AW  = TIME_BITS + 2;
	localparam int unsigned EW  = TIME_BITS + 4;
	localparam int unsigned XW  = FW + CB;
	localparam int unsigned NBW = $clog2(XW + 1);
	localparam int unsigned PYW = FW + CB;
	localparam int unsigned YSW = ((PYW > YW) ? PYW : YW) + 1;

	// Animation state.
	logic [FW-1:0]          frame_now_q;
	logic signed [AW-1:0]   acc_q;
	logic [MAX_FRAMES-1:0]  dur_vld_q;

	// Working registers of one tick.
	logic [FW-1:0]          f_q;
	logic [TB-1:0]          delta_q;
	logic [TB-1:0]          dur_q;
	logic signed [EW-1:0]   a_q;
	logic signed [EW-1:0]   ad_q;
	logic signed [EW-1:0]   gap_q;
	logic signed [EW-1:0]   after_q;
	logic [XW-1:0]          prod_x_q;
	logic [XW-1:0]          num_x_q;
	logic [CB-1:0]          per_row_q;
	logic [CB-1:0]          x_q;
	logic [PYW-1:0]         prod_y_q;
	logic                   rect_valid_q;

	logic [TB-1:0]          ram_rdata;
	logic                   idx_ok;

	logic signed [EW-1:0]   acc_ext;
	logic signed [EW-1:0]   delta_ext;
	logic signed [EW-1:0]   delta2_ext;
	logic signed [EW-1:0]   dur_ext;
	logic signed [EW-1:0]   after_abs;
	logic signed [EW-1:0]   acc_nx;
	logic signed [EW-1:0]   acc_sat;
	logic signed [EW-1:0]   acc_max;
	logic signed [EW-1:0]   acc_min;
	logic                   advance;

	logic [FW:0]            cnt_eff;
	logic [FW:0]            f_inc;
	logic [FW-1:0]          f_next;

	logic [CB-1:0]          sw_eff;
	logic [CB-1:0]          fw_eff;
	logic [XW-1:0]          div_dividend;
	logic [NBW-1:0]         div_nbits;
	logic [CB-1:0]          div_divisor;
	logic                   div_done;
	logic [XW-1:0]          div_quot;
	logic [CB-1:0]          div_rem;
	logic [YSW-1:0]         y_sum;

	// Frame durations: RAM plus one valid bit per entry, so unloaded
	// entries read as zero after reset.
	assign idx_ok = (32'(entry_index) < MAX_FRAMES);

	sfs_ram #(
		.WIDTH (TB),
		.DEPTH (MAX_FRAMES)
	) u_dur_ram (
		.clk   (clk),
		.we    (ctl.load_dur && idx_ok),
		.waddr (entry_index),
		.wdata (duration),
		.re    (ctl.take_tick),
		.raddr (frame_now_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_vld_q <= '0;
		end else if (ctl.load_dur && idx_ok) begin
			dur_vld_q[entry_index] <= 1'b1;
		end
	end

	// Sign and zero extensions into the working width.
	assign acc_ext    = {{(EW-AW){acc_q[AW-1]}}, acc_q};
	assign delta_ext  = {{(EW-TB){1'b0}}, delta_q};
	assign delta2_ext = {{(EW-TB-1){1'b0}}, delta_q, 1'b0};
	assign dur_ext    = {{(EW-TB){1'b0}}, dur_q};
	assign acc_max    = {{(EW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	assign acc_min    = ~acc_max;

	// Advance decision: due when the gap is not positive, or early when the
	// gap is smaller than the distance after one more equal tick.
	assign after_abs = after_q[EW-1] ? -after_q : after_q;
	assign advance   = gap_q[EW-1] || (gap_q == '0) || (gap_q < after_abs);
	assign acc_nx    = advance ? -gap_q : a_q;

	always_comb begin
		if (acc_nx > acc_max) begin
			acc_sat = acc_max;
		end else if (acc_nx < acc_min) begin
			acc_sat = acc_min;
		end else begin
			acc_sat = acc_nx;
		end
	end

	// Next frame index, wrapping at the clamped frame count.
	always_comb begin
		if (frame_count == '0) begin
			cnt_eff = (FW+1)'(1);
		end else if (32'(frame_count) > MAX_FRAMES) begin
			cnt_eff = (FW+1)'(MAX_FRAMES);
		end else begin
			cnt_eff = (FW+1)'(frame_count);
		end
	end

	assign f_inc  = {1'b0, f_q} + (FW+1)'(1);
	assign f_next = (f_inc >= cnt_eff) ? '0 : f_inc[FW-1:0];

	// Frame counter and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_now_q <= '0;
			acc_q       <= '0;
		end else if (ctl.restart) begin
			frame_now_q <= '0;
			acc_q       <= '0;
		end else if (ctl.decide) begin
			acc_q <= acc_sat[AW-1:0];
			if (advance) begin
				frame_now_q <= f_next;
			end
		end
	end

	// Timing arithmetic and the x numerator: the fetch stage forms the sums and the x product, the step stage the rest.
	always_ff @(posedge clk) begin
		if (ctl.take_tick) begin
			f_q     <= frame_now_q;
			delta_q <= delta;
		end
		if (ctl.fetch) begin
			dur_q    <= dur_vld_q[f_q] ? ram_rdata : '0;
			a_q      <= acc_ext + delta_ext;
			ad_q     <= acc_ext + delta2_ext;
			prod_x_q <= {{CB{1'b0}}, f_q} * {{FW{1'b0}}, frame_width};
		end
		if (ctl.step) begin
			gap_q   <= dur_ext - a_q;
			after_q <= dur_ext - ad_q;
			num_x_q <= prod_x_q + XW'(origin_x);
		end
	end

	// Operand selection for the shared divider.
	assign sw_eff = (sheet_width == '0) ? CB'(1) : sheet_width;
	assign fw_eff = (frame_width == '0) ? CB'(1) : frame_width;

	always_comb begin
		case (ctl.div_op)
			sfs_pkg::DIV_ROW: begin
				div_dividend = {sw_eff, {FW{1'b0}}};
				div_nbits    = NBW'(CB);
				div_divisor  = fw_eff;
			end
			sfs_pkg::DIV_X: begin
				div_dividend = num_x_q;
				div_nbits    = NBW'(XW);
				div_divisor  = sw_eff;
			end
			sfs_pkg::DIV_Y: begin
				div_dividend = {f_q, {CB{1'b0}}};
				div_nbits    = NBW'(FW);
				div_divisor  = per_row_q;
			end
			default: begin
				div_dividend = {sw_eff, {FW{1'b0}}};
				div_nbits    = NBW'(CB);
				div_divisor  = fw_eff;
			end
		endcase
	end

	sfs_div #(
		.DW (XW),
		.VW (CB)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (div_dividend),
		.nbits     (div_nbits),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Division results.
	always_ff @(posedge clk) begin
		if (ctl.row_latch) begin
			per_row_q <= (div_quot[CB-1:0] == '0) ? CB'(1) : div_quot[CB-1:0];
		end
		if (ctl.x_latch) begin
			x_q <= div_rem;
		end
		if (ctl.y_latch) begin
			prod_y_q <= {{CB{1'b0}}, div_quot[FW-1:0]} * {{FW{1'b0}}, frame_height};
		end
	end

	// Output register: it holds a finished rectangle while the next request
	// is already being taken.
	assign y_sum = YSW'(prod_y_q) + YSW'(origin_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			rect_valid_q <= 1'b1;
		end else if (rect_ready) begin
			rect_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			src_x       <= x_q;
			src_y       <= y_sum[YW-1:0];
			src_w       <= frame_width;
			src_h       <= frame_height;
			shown_frame <= f_q;
		end
	end

	assign rect_valid   = rect_valid_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !rect_valid_q || rect_ready;

endmodule

// ----- hw/rtl/sprite_frame_sequencer.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Carries
// cmd       in         valid/ready          action, delta, entry_index, duration
// rect      out        valid/ready          src_x, src_y, src_w, src_h, shown_frame
// apb       in         psel/penable/pready  configuration register writes and reads
//
// A tick runs the timing update, then three passes of the bit-serial divider
// (COORD_BITS, log2(MAX_FRAMES)+COORD_BITS and log2(MAX_FRAMES) quotient bits),
// then loads the output. Loads, restarts and the unused action code are done
// as they are accepted, in the idle state.
// Reset is asynchronous, active low; the duration store reads as zero until
// an entry is loaded. A stalled rect channel holds one finished rectangle
// while the next request is taken; the one after waits for it to go.
module sprite_frame_sequencer #(
	parameter int unsigned MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
	parameter int unsigned TIME_BITS  = sfs_pkg::TIME_BITS_DEF,
	parameter int unsigned COORD_BITS = sfs_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sfs_cmd_if.sink                       cmd,
	sfs_rect_if.source                    rect,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sfs_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sfs_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready
);

	localparam int unsigned FW   = $clog2(MAX_FRAMES);
	localparam int unsigned CNTW = $clog2(MAX_FRAMES + 1);

	logic [COORD_BITS-1:0] frame_width;
	logic [COORD_BITS-1:0] frame_height;
	logic [COORD_BITS-1:0] origin_x;
	logic [COORD_BITS-1:0] origin_y;
	logic [COORD_BITS-1:0] sheet_width;
	logic [CNTW-1:0]       frame_count;

	sfs_pkg::ctl_cmd_t ctl;
	sfs_pkg::ctl_sts_t sts;

	// Configuration registers.
	sfs_regs #(
		.COORD_BITS (COORD_BITS),
		.CNT_BITS   (CNTW)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.sheet_width  (sheet_width),
		.frame_count  (frame_count)
	);

	// Controller.
	sfs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_action (cmd.action),
		.cmd_ready  (cmd.ready),
		.sts        (sts),
		.ctl        (ctl)
	);

	// Datapath.
	sfs_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.TIME_BITS  (TIME_BITS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.delta        (cmd.delta),
		.entry_index  (cmd.entry_index[FW-1:0]),
		.duration     (cmd.duration),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.sheet_width  (sheet_width),
		.frame_count  (frame_count),
		.rect_ready   (rect.ready),
		.rect_valid   (rect.valid),
		.src_x        (rect.src_x),
		.src_y        (rect.src_y),
		.src_w        (rect.src_w),
		.src_h        (rect.src_h),
		.shown_frame  (rect.shown_frame)
	);

endmodule

// ----- hw/rtl/sfs_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks on the sequencer.
module sfs_checker #(
	parameter int unsigned RW = 56
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input logic [1:0]    cmd_action,
	input logic          rect_valid,
	input logic          rect_ready,
	input logic [RW-1:0] rect_data
);

	logic       tick_acc;
	logic       rect_acc;
	logic [1:0] pend_q;

	assign tick_acc = cmd_valid && cmd_ready && (cmd_action == sfs_pkg::ACT_TICK);
	assign rect_acc = rect_valid && rect_ready;

	// Ticks taken whose rectangle has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(tick_acc) - 2'(rect_acc);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rect_valid && !rect_ready |=> rect_valid)
		else $error("rect valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rect_valid && !rect_ready |=> $stable(rect_data))
		else $error("rect payload changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rect_valid |-> (pend_q != 2'd0))
		else $error("rectangle offered without a pending tick");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |-> (pend_q < 2'd2))
		else $error("tick taken with two ticks already pending");

endmodule

bind sprite_frame_sequencer sfs_checker #(
	.RW (3 * COORD_BITS + COORD_BITS + 4 + FW)
) u_sfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_action (cmd.action),
	.rect_valid (rect.valid),
	.rect_ready (rect.ready),
	.rect_data  ({rect.src_x, rect.src_y, rect.src_w, rect.src_h, rect.shown_frame})
);
